// ===== hw/rtl/ppq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Partitioned priority queue package
// Sizes, word layouts, status codes and the segment length table.
// ----------------------------------------------------------------------------
package ppq_pkg;

   localparam int DEPTH      = 16;
   localparam int MAX_LEVELS = 8;

   localparam int LVL_W  = 4;
   localparam int VAL_W  = 32;
   localparam int CNT_W  = 4;
   localparam int STAT_W = 2;

   localparam int OFF_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int Q_W    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int MUL_W  = Q_W + OFF_W;

   localparam int REQ_DATA_W = ((LVL_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((VAL_W + LVL_W + 7) / 8) * 8;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef logic [OFF_W-1:0] off_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic             kind;
      logic [LVL_W-1:0] level;
      logic [VAL_W-1:0] value;
   } req_type;

   // Segment length for n levels: DEPTH / n, all divisions by constants.
   function automatic off_type seg_len_of(input logic [CNT_W-1:0] n);
      case (n)
         4'd2:    seg_len_of = OFF_W'(DEPTH / 2);
         4'd3:    seg_len_of = OFF_W'(DEPTH / 3);
         4'd4:    seg_len_of = OFF_W'(DEPTH / 4);
         4'd5:    seg_len_of = OFF_W'(DEPTH / 5);
         4'd6:    seg_len_of = OFF_W'(DEPTH / 6);
         4'd7:    seg_len_of = OFF_W'(DEPTH / 7);
         4'd8:    seg_len_of = OFF_W'(DEPTH / 8);
         4'd9:    seg_len_of = OFF_W'(DEPTH / 9);
         4'd10:   seg_len_of = OFF_W'(DEPTH / 10);
         4'd11:   seg_len_of = OFF_W'(DEPTH / 11);
         4'd12:   seg_len_of = OFF_W'(DEPTH / 12);
         4'd13:   seg_len_of = OFF_W'(DEPTH / 13);
         4'd14:   seg_len_of = OFF_W'(DEPTH / 14);
         4'd15:   seg_len_of = OFF_W'(DEPTH / 15);
         default: seg_len_of = OFF_W'(DEPTH);
      endcase
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ppq_in_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Partitioned priority queue input register
// Unpacks the request word and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module ppq_in_reg (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [ppq_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [0:0]                      req_tuser,
   input  wire logic                            take,
   output      logic                            in_valid,
   output      ppq_pkg::req_type                in_word
);

   logic             valid_ff;
   ppq_pkg::req_type word_ff;
   ppq_pkg::req_type word_in;

   assign req_tready = !valid_ff || take;

   always_comb begin
      word_in.kind  = req_tuser[0];
      word_in.level = req_tdata[ppq_pkg::LVL_W-1:0];
      word_in.value = req_tdata[ppq_pkg::LVL_W +: ppq_pkg::VAL_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         word_ff <= word_in;
      end
   end

   assign in_valid = valid_ff;
   assign in_word  = word_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ppq_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Partitioned priority queue engine
// Per-level offsets, word store, priority select and the result register.
// ----------------------------------------------------------------------------
module ppq_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire ppq_pkg::req_type             in_word,
   output      logic                         take,
   input  wire logic                         csr_we,
   input  wire logic [ppq_pkg::CNT_W-1:0]    csr_wdata,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      ppq_pkg::status_type          rsp_status,
   output      logic [ppq_pkg::VAL_W-1:0]    rsp_value,
   output      logic [ppq_pkg::LVL_W-1:0]    rsp_level
);

   localparam int ML = ppq_pkg::MAX_LEVELS;

   ppq_pkg::off_type head_ff [ML];
   ppq_pkg::off_type tail_ff [ML];
   ppq_pkg::off_type head_in [ML];
   ppq_pkg::off_type tail_in [ML];
   ppq_pkg::off_type seg_len_ff, seg_len_in;
   logic [ppq_pkg::CNT_W-1:0] level_count_ff, level_count_in;
   logic [ppq_pkg::CNT_W-1:0] n_sat;

   logic [ppq_pkg::VAL_W-1:0] mem [ppq_pkg::DEPTH];
   logic [ppq_pkg::VAL_W-1:0] rd_data_ff;

   logic                        rsp_valid_ff;
   ppq_pkg::status_type         status_ff, status_in;
   logic [ppq_pkg::LVL_W-1:0]   served_ff, served_in;
   logic                        hit_ff;

   logic                        is_ins, lvl_ok, ins_ok, rem_hit;
   logic [ppq_pkg::Q_W-1:0]     q, sel_q;
   ppq_pkg::off_type            tail_q, head_sel, head_next;
   logic [ML-1:0]               nonempty;
   logic [ppq_pkg::MUL_W-1:0]   wr_sum, rd_sum;
   logic [ppq_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
   logic                        wr_en;

   assign take = in_valid && (!rsp_valid_ff || rsp_ready);

   // insert side
   assign is_ins = (in_word.kind == ppq_pkg::KIND_INSERT);
   assign q      = ppq_pkg::Q_W'(in_word.level - ppq_pkg::LVL_W'(1));
   assign lvl_ok = (in_word.level != '0) && (in_word.level <= level_count_ff)
                   && (int'(in_word.level) <= ML);
   assign tail_q = tail_ff[q];
   assign ins_ok = lvl_ok && (tail_q < seg_len_ff);
   assign wr_sum = ppq_pkg::MUL_W'(q) * ppq_pkg::MUL_W'(seg_len_ff)
                   + ppq_pkg::MUL_W'(tail_q);
   assign wr_addr = wr_sum[ppq_pkg::ADDR_W-1:0];
   assign wr_en   = take && is_ins && ins_ok;

   // remove side: lowest-numbered non-empty level wins
   always_comb begin
      for (int i = 0; i < ML; i++) begin
         nonempty[i] = (ppq_pkg::CNT_W'(i) < level_count_ff) && (head_ff[i] != tail_ff[i]);
      end
      sel_q = '0;
      for (int i = ML - 1; i >= 0; i--) begin
         if (nonempty[i]) begin
            sel_q = ppq_pkg::Q_W'(i);
         end
      end
   end

   assign rem_hit   = |nonempty;
   assign head_sel  = head_ff[sel_q];
   assign head_next = head_sel + ppq_pkg::OFF_W'(1);
   assign rd_sum    = ppq_pkg::MUL_W'(sel_q) * ppq_pkg::MUL_W'(seg_len_ff)
                      + ppq_pkg::MUL_W'(head_sel);
   assign rd_addr   = rd_sum[ppq_pkg::ADDR_W-1:0];

   // register write: clamp the count and empty every level
   always_comb begin
      n_sat = csr_wdata;
      if (csr_wdata == '0) begin
         n_sat = ppq_pkg::CNT_W'(1);
      end else if (int'(csr_wdata) > ML) begin
         n_sat = ppq_pkg::CNT_W'(ML);
      end
   end

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      level_count_in = level_count_ff;
      seg_len_in     = seg_len_ff;
      if (csr_we) begin
         level_count_in = n_sat;
         seg_len_in     = ppq_pkg::seg_len_of(n_sat);
         for (int i = 0; i < ML; i++) begin
            head_in[i] = '0;
            tail_in[i] = '0;
         end
      end else if (take) begin
         if (is_ins && ins_ok) begin
            tail_in[q] = tail_q + ppq_pkg::OFF_W'(1);
         end else if (!is_ins && rem_hit) begin
            // reclaim the segment once the level drains
            if (head_next == tail_ff[sel_q]) begin
               head_in[sel_q] = '0;
               tail_in[sel_q] = '0;
            end else begin
               head_in[sel_q] = head_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= ppq_pkg::CNT_W'(1);
         seg_len_ff     <= ppq_pkg::OFF_W'(ppq_pkg::DEPTH);
         for (int i = 0; i < ML; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         level_count_ff <= level_count_in;
         seg_len_ff     <= seg_len_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= in_word.value;
      end
      if (take) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // result
   always_comb begin
      if (is_ins) begin
         status_in = ins_ok ? ppq_pkg::ST_DONE : ppq_pkg::ST_FULL;
         served_in = '0;
      end else begin
         status_in = rem_hit ? ppq_pkg::ST_DONE : ppq_pkg::ST_EMPTY;
         served_in = rem_hit ? ppq_pkg::LVL_W'(sel_q) + ppq_pkg::LVL_W'(1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= status_in;
         served_ff <= served_in;
         hit_ff    <= !is_ins && rem_hit;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_level  = served_ff;
   assign rsp_value  = hit_ff ? rd_data_ff : '0;

   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff[0] <= tail_ff[0])
      else $error("level 1 head passed its tail");

   a_tail_le_seg: assert property (@(posedge clock) disable iff (reset)
      tail_ff[0] <= seg_len_ff)
      else $error("level 1 tail beyond segment length");

   a_cfg_empties: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (head_ff[0] == '0) && (tail_ff[0] == '0) && !(|nonempty))
      else $error("register write left a level non-empty");

   a_hit_level: assert property (@(posedge clock) disable iff (reset)
      (take && !is_ins && rem_hit) |=> rsp_valid_ff && (served_ff != '0)
                                        && (status_ff == ppq_pkg::ST_DONE))
      else $error("served remove without a level");

   a_refused: assert property (@(posedge clock) disable iff (reset)
      (take && is_ins && !ins_ok) |=> (status_ff == ppq_pkg::ST_FULL) && !hit_ff)
      else $error("refused insert not reported full");

endmodule
`default_nettype wire

// ===== hw/rtl/partitioned_priority_queue_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Partitioned priority queue unit
// A store of DEPTH words split into equal segments, one FIFO per level.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per operation. tuser[0] = kind (0 insert, 1 remove),
//   tdata = level and value. Every request gives exactly one rsp word.
//   rsp channel: tuser = status (done, full, all empty), tdata = removed
//   value and serving level; both zero when nothing was removed.
//   csr_we/csr_wdata set the number of levels (clamped to 1..MAX_LEVELS);
//   each write empties every level. Write only while no request is pending.
// Timing:
//   A request waits in the input register until the result register is free
//   or being read, and is then executed into the result register, which
//   drives rsp_tvalid. One request per cycle is sustained while rsp_tready
//   is high, limited by the single write and single read port of the word store.
// Reset and stall:
//   Reset gives one level with the whole store and every level empty.
//   When rsp_tready is low the result is held, the input register fills, and
//   req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module partitioned_priority_queue_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [ppq_pkg::REQ_DATA_W-1:0]  req_tdata,  // level[3:0], value[35:4]
   input  wire logic [0:0]                      req_tuser,  // kind[0]
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [ppq_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // removed_value[31:0], served_level[35:32]
   output      logic [ppq_pkg::STAT_W-1:0]      rsp_tuser,  // status[1:0]
   input  wire logic                            csr_we,
   input  wire logic [ppq_pkg::CNT_W-1:0]       csr_wdata
);

   logic                       take;
   logic                       in_valid;
   ppq_pkg::req_type           in_word;
   ppq_pkg::status_type        status;
   logic [ppq_pkg::VAL_W-1:0]  removed_value;
   logic [ppq_pkg::LVL_W-1:0]  served_level;

   ppq_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .in_valid   (in_valid),
      .in_word    (in_word)
   );

   ppq_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid),
      .in_word    (in_word),
      .take       (take),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (status),
      .rsp_value  (removed_value),
      .rsp_level  (served_level)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = ppq_pkg::RSP_DATA_W'({served_level, removed_value});

endmodule
`default_nettype wire
